// ----- sv/note_to_midi_event_encoder_top_defines.svh -----
// Assertion macros for the note to MIDI event encoder.
// Used by note_to_midi_event_encoder_top; expects clk and arst_n in scope.
`ifndef NOTE_TO_MIDI_EVENT_ENCODER_TOP_DEFINES_SVH
`define NOTE_TO_MIDI_EVENT_ENCODER_TOP_DEFINES_SVH

// same-cycle implication
`define NMEE_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nmee: same-cycle check failed");

// next-cycle implication
`define NMEE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nmee: next-cycle check failed");

`endif

// ----- sv/nmee_pkg.sv -----
// Shared types, constants and VLQ helper functions of the note to MIDI event encoder.
// No dependencies.
package nmee_pkg;

	localparam int VLQ_MAX_BYTES = 4;
	localparam int TICK_W        = 28;
	localparam int TICK_BITS     = (7 * VLQ_MAX_BYTES < TICK_W) ? 7 * VLQ_MAX_BYTES : TICK_W;
	localparam logic [TICK_W-1:0] TICK_MAX = TICK_W'((64'd1 << TICK_BITS) - 64'd1);
	localparam int EXT_W         = (7 * VLQ_MAX_BYTES > TICK_W) ? 7 * VLQ_MAX_BYTES : TICK_W;
	localparam int GRP_W         = (VLQ_MAX_BYTES > 1) ? $clog2(VLQ_MAX_BYTES) : 1;

	localparam int TC_W    = 15;
	localparam int VEL_W   = 7;
	localparam int PITCH_W = 7;
	localparam int DUR_W   = 24;
	localparam int FRAC_W  = 8;
	localparam int BYTE_W  = 8;
	localparam int CFG_W   = 15;
	localparam int PROD_W  = DUR_W + TC_W;
	localparam int SHR_W   = PROD_W - FRAC_W;

	// depth must be a power of two so the pointers wrap
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam logic REG_TIME_CLOCK    = 1'b0;
	localparam logic REG_NOTE_VELOCITY = 1'b1;

	localparam logic [BYTE_W-1:0] NOTE_ON_BYTE  = 8'h90;
	localparam logic [BYTE_W-1:0] NOTE_OFF_BYTE = 8'h80;
	localparam logic [BYTE_W-1:0] EOT_DELTA     = 8'h01;
	localparam logic [BYTE_W-1:0] META_BYTE     = 8'hFF;
	localparam logic [BYTE_W-1:0] EOT_TYPE      = 8'h2F;
	localparam logic [BYTE_W-1:0] ZERO_BYTE     = 8'h00;

	localparam logic [TC_W-1:0]  TIME_CLOCK_RST = 15'd96;
	localparam logic [VEL_W-1:0] VELOCITY_RST   = 7'h47;

	typedef struct packed {
		logic               note;
		logic               final_item;
		logic [PITCH_W-1:0] pitch;
		logic [TICK_W-1:0]  delta;
		logic [TICK_W-1:0]  ticks;
	} cmd_t;

	typedef struct packed {
		logic commit;
		logic final_item;
		logic pending_zero;
	} front_stat_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_DELTA,
		BK_ON,
		BK_PITCH_ON,
		BK_VEL,
		BK_LEN,
		BK_OFF,
		BK_PITCH_OFF,
		BK_VEL_OFF,
		BK_EOT_DELTA,
		BK_EOT_META,
		BK_EOT_TYPE,
		BK_EOT_LEN
	} bk_state_t;

	// index of the most significant 7-bit group to send
	function automatic logic [GRP_W-1:0] vlq_top(input logic [TICK_W-1:0] v);
		logic [EXT_W-1:0] ext;
		logic [GRP_W-1:0] top;
		ext = EXT_W'(v);
		top = '0;
		for (int i = 1; i < VLQ_MAX_BYTES; i++) begin
			if ((ext >> (7 * i)) != '0) begin
				top = GRP_W'(i);
			end
		end
		return top;
	endfunction

	function automatic logic [6:0] vlq_group(input logic [TICK_W-1:0] v,
		input logic [GRP_W-1:0] g);
		logic [EXT_W-1:0] ext;
		logic [6:0]       grp;
		ext = EXT_W'(v);
		grp = '0;
		for (int i = 0; i < VLQ_MAX_BYTES; i++) begin
			if (g == GRP_W'(i)) begin
				grp = ext[7 * i +: 7];
			end
		end
		return grp;
	endfunction

endpackage

// ----- sv/note_to_midi_event_encoder_top.sv -----
// Top level of the note to MIDI event encoder: configuration registers, front end,
// command queue and byte sequencer. Depends on nmee_pkg, nmee_front, nmee_fifo, nmee_back.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+-----------------------------------------
//  in        | in_valid / in_ready   | is_rest, pitch, duration, final_item
//  out       | out_valid / out_ready | out_byte, last_byte
//  cfg       | cfg_we                | cfg_index, cfg_data
//
// One byte per cycle leaves the sequencer while out_ready does not stall it; a note takes
// 6 + delta VLQ + length VLQ bytes (8 to 14), plus 4 when final; a final rest takes 4.
// A non-final rest takes none. The front takes one request per cycle while the 4-entry
// queue has room; the first byte of a request passes the front register, the queue, the
// sequencer state and the output register. The byte sequencer sets the rate.
// Reset clears the pending delta, queue, sequencer and output valid; no clearing pass.
`include "note_to_midi_event_encoder_top_defines.svh"

module note_to_midi_event_encoder_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [nmee_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           is_rest,
	input  logic [nmee_pkg::PITCH_W-1:0]   pitch,
	input  logic [nmee_pkg::DUR_W-1:0]     duration,
	input  logic                           final_item,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [nmee_pkg::BYTE_W-1:0]    out_byte,
	output logic                           last_byte
);

	logic [nmee_pkg::TC_W-1:0]     time_clock_q;
	logic [nmee_pkg::VEL_W-1:0]    note_velocity_q;

	logic                          push_valid;
	logic                          push_ready;
	nmee_pkg::cmd_t                push_cmd;
	nmee_pkg::front_stat_t         front_stat;
	logic                          head_valid;
	nmee_pkg::cmd_t                head;
	logic                          pop;
	logic [nmee_pkg::FIFO_CW-1:0]  fifo_level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_clock_q    <= nmee_pkg::TIME_CLOCK_RST;
			note_velocity_q <= nmee_pkg::VELOCITY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				nmee_pkg::REG_TIME_CLOCK: begin
					time_clock_q <= cfg_data[nmee_pkg::TC_W-1:0];
				end
				nmee_pkg::REG_NOTE_VELOCITY: begin
					note_velocity_q <= cfg_data[nmee_pkg::VEL_W-1:0];
				end
				default: begin
					time_clock_q <= time_clock_q;
				end
			endcase
		end
	end

	nmee_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.is_rest    (is_rest),
		.pitch      (pitch),
		.duration   (duration),
		.final_item (final_item),
		.time_clock (time_clock_q),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.push_ready (push_ready),
		.stat       (front_stat)
	);

	nmee_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.push_ready (push_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head),
		.level      (fifo_level)
	);

	nmee_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.note_velocity (note_velocity_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.last_byte     (last_byte)
	);

	`NMEE_ASSERT_SAME(a_fifo_bound, 1'b1, fifo_level <= nmee_pkg::FIFO_CW'(nmee_pkg::FIFO_DEPTH))
	`NMEE_ASSERT_NEXT(a_final_clears, front_stat.commit && front_stat.final_item, front_stat.pending_zero)
	`NMEE_ASSERT_NEXT(a_level_no_push, !(push_valid && push_ready), fifo_level <= $past(fifo_level))

endmodule

// ----- sv/nmee_front.sv -----
// Front end: accepts notes and rests, scales durations to ticks, keeps the pending delta
// and issues event commands. Depends on nmee_pkg.
module nmee_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             is_rest,
	input  logic [nmee_pkg::PITCH_W-1:0]     pitch,
	input  logic [nmee_pkg::DUR_W-1:0]       duration,
	input  logic                             final_item,
	input  logic [nmee_pkg::TC_W-1:0]        time_clock,
	output logic                             push_valid,
	output nmee_pkg::cmd_t                   push_cmd,
	input  logic                             push_ready,
	output nmee_pkg::front_stat_t            stat
);

	logic                             valid_s1;
	logic                             rest_s1;
	logic                             final_s1;
	logic [nmee_pkg::PITCH_W-1:0]     pitch_s1;
	logic [nmee_pkg::PROD_W-1:0]      prod_s1;
	logic [nmee_pkg::TICK_W-1:0]      pending_q;

	logic [nmee_pkg::SHR_W-1:0]       scaled;
	logic [nmee_pkg::TICK_W-1:0]      ticks;
	logic [nmee_pkg::TICK_W:0]        sum;
	logic [nmee_pkg::TICK_W-1:0]      sum_sat;
	logic                             need_push;
	logic                             advance;

	assign scaled = prod_s1[nmee_pkg::PROD_W-1:nmee_pkg::FRAC_W];
	assign ticks  = (scaled > nmee_pkg::SHR_W'(nmee_pkg::TICK_MAX)) ? nmee_pkg::TICK_MAX
		: scaled[nmee_pkg::TICK_W-1:0];
	assign sum     = {1'b0, pending_q} + {1'b0, ticks};
	assign sum_sat = (sum > {1'b0, nmee_pkg::TICK_MAX}) ? nmee_pkg::TICK_MAX
		: sum[nmee_pkg::TICK_W-1:0];

	assign need_push  = !rest_s1 || final_s1;
	assign advance    = valid_s1 && (!need_push || push_ready);
	assign in_ready   = !valid_s1 || advance;
	assign push_valid = valid_s1 && need_push;

	assign push_cmd.note       = !rest_s1;
	assign push_cmd.final_item = final_s1;
	assign push_cmd.pitch      = pitch_s1;
	assign push_cmd.delta      = pending_q;
	assign push_cmd.ticks      = ticks;

	assign stat.commit       = advance;
	assign stat.final_item   = final_s1;
	assign stat.pending_zero = (pending_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			pending_q <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				if (need_push) begin
					pending_q <= '0;
				end else begin
					pending_q <= sum_sat;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rest_s1  <= is_rest;
			final_s1 <= final_item;
			pitch_s1 <= pitch;
			prod_s1  <= nmee_pkg::PROD_W'(duration) * nmee_pkg::PROD_W'(time_clock);
		end
	end

endmodule

// ----- sv/nmee_fifo.sv -----
// Command queue between front and back end.
// Depends on nmee_pkg.
module nmee_fifo (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push_valid,
	input  nmee_pkg::cmd_t               push_cmd,
	output logic                         push_ready,
	input  logic                         pop,
	output logic                         head_valid,
	output nmee_pkg::cmd_t               head,
	output logic [nmee_pkg::FIFO_CW-1:0] level
);

	nmee_pkg::cmd_t                 mem_q [nmee_pkg::FIFO_DEPTH];
	logic [nmee_pkg::FIFO_AW-1:0]   wr_q;
	logic [nmee_pkg::FIFO_AW-1:0]   rd_q;
	logic [nmee_pkg::FIFO_CW-1:0]   cnt_q;
	logic                           do_push;
	logic                           do_pop;

	assign push_ready = (cnt_q != nmee_pkg::FIFO_CW'(nmee_pkg::FIFO_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];
	assign level      = cnt_q;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

endmodule

// ----- sv/nmee_back.sv -----
// Back end: byte sequencer that expands each command into MIDI event bytes,
// with a registered output stage. Depends on nmee_pkg.
module nmee_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  nmee_pkg::cmd_t                head,
	output logic                          pop,
	input  logic [nmee_pkg::VEL_W-1:0]    note_velocity,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [nmee_pkg::BYTE_W-1:0]   out_byte,
	output logic                          last_byte
);

	nmee_pkg::bk_state_t            state_q;
	nmee_pkg::bk_state_t            state_d;
	nmee_pkg::bk_state_t            phase_next;
	logic [nmee_pkg::GRP_W-1:0]     grp_q;
	logic [nmee_pkg::GRP_W-1:0]     grp_d;
	logic [nmee_pkg::GRP_W-1:0]     ticks_top_q;
	nmee_pkg::cmd_t                 cur_q;
	logic                           out_valid_q;
	logic [nmee_pkg::BYTE_W-1:0]    out_byte_q;
	logic                           last_byte_q;

	logic [nmee_pkg::BYTE_W-1:0]    byte_c;
	logic                           last_c;
	logic                           cmd_done;
	logic                           in_vlq;
	logic                           load_ok;
	logic                           emit;

	assign load_ok   = !out_valid_q || out_ready;
	assign emit      = (state_q != nmee_pkg::BK_IDLE) && load_ok;
	assign pop       = head_valid && ((state_q == nmee_pkg::BK_IDLE) || (emit && cmd_done));
	assign in_vlq    = (state_q == nmee_pkg::BK_DELTA) || (state_q == nmee_pkg::BK_LEN);
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last_byte = last_byte_q;

	// byte of the current step
	always_comb begin
		byte_c   = nmee_pkg::ZERO_BYTE;
		last_c   = 1'b0;
		cmd_done = 1'b0;
		unique case (state_q)
			nmee_pkg::BK_IDLE: begin
				byte_c = nmee_pkg::ZERO_BYTE;
			end
			nmee_pkg::BK_DELTA: begin
				byte_c = {grp_q != '0, nmee_pkg::vlq_group(cur_q.delta, grp_q)};
			end
			nmee_pkg::BK_ON: begin
				byte_c = nmee_pkg::NOTE_ON_BYTE;
			end
			nmee_pkg::BK_PITCH_ON: begin
				byte_c = {1'b0, cur_q.pitch};
			end
			nmee_pkg::BK_VEL: begin
				byte_c = {1'b0, note_velocity};
			end
			nmee_pkg::BK_LEN: begin
				byte_c = {grp_q != '0, nmee_pkg::vlq_group(cur_q.ticks, grp_q)};
			end
			nmee_pkg::BK_OFF: begin
				byte_c = nmee_pkg::NOTE_OFF_BYTE;
			end
			nmee_pkg::BK_PITCH_OFF: begin
				byte_c = {1'b0, cur_q.pitch};
			end
			nmee_pkg::BK_VEL_OFF: begin
				byte_c   = nmee_pkg::ZERO_BYTE;
				cmd_done = !cur_q.final_item;
				last_c   = !cur_q.final_item;
			end
			nmee_pkg::BK_EOT_DELTA: begin
				byte_c = nmee_pkg::EOT_DELTA;
			end
			nmee_pkg::BK_EOT_META: begin
				byte_c = nmee_pkg::META_BYTE;
			end
			nmee_pkg::BK_EOT_TYPE: begin
				byte_c = nmee_pkg::EOT_TYPE;
			end
			nmee_pkg::BK_EOT_LEN: begin
				byte_c   = nmee_pkg::ZERO_BYTE;
				cmd_done = 1'b1;
				last_c   = 1'b1;
			end
			default: begin
				byte_c = nmee_pkg::ZERO_BYTE;
			end
		endcase
	end

	always_comb begin
		unique case (state_q)
			nmee_pkg::BK_DELTA:     phase_next = nmee_pkg::BK_ON;
			nmee_pkg::BK_ON:        phase_next = nmee_pkg::BK_PITCH_ON;
			nmee_pkg::BK_PITCH_ON:  phase_next = nmee_pkg::BK_VEL;
			nmee_pkg::BK_VEL:       phase_next = nmee_pkg::BK_LEN;
			nmee_pkg::BK_LEN:       phase_next = nmee_pkg::BK_OFF;
			nmee_pkg::BK_OFF:       phase_next = nmee_pkg::BK_PITCH_OFF;
			nmee_pkg::BK_PITCH_OFF: phase_next = nmee_pkg::BK_VEL_OFF;
			nmee_pkg::BK_VEL_OFF:   phase_next = nmee_pkg::BK_EOT_DELTA;
			nmee_pkg::BK_EOT_DELTA: phase_next = nmee_pkg::BK_EOT_META;
			nmee_pkg::BK_EOT_META:  phase_next = nmee_pkg::BK_EOT_TYPE;
			nmee_pkg::BK_EOT_TYPE:  phase_next = nmee_pkg::BK_EOT_LEN;
			default:                phase_next = nmee_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		state_d = state_q;
		grp_d   = grp_q;
		priority if (pop) begin
			state_d = head.note ? nmee_pkg::BK_DELTA : nmee_pkg::BK_EOT_DELTA;
			grp_d   = nmee_pkg::vlq_top(head.delta);
		end else if (emit) begin
			priority if (cmd_done) begin
				state_d = nmee_pkg::BK_IDLE;
			end else if (in_vlq && grp_q != '0) begin
				grp_d = grp_q - 1'b1;
			end else begin
				state_d = phase_next;
				if (state_q == nmee_pkg::BK_VEL) begin
					grp_d = ticks_top_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nmee_pkg::BK_IDLE;
			grp_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			grp_q   <= grp_d;
			if (load_ok) begin
				out_valid_q <= (state_q != nmee_pkg::BK_IDLE);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q       <= head;
			ticks_top_q <= nmee_pkg::vlq_top(head.ticks);
		end
		if (emit) begin
			out_byte_q  <= byte_c;
			last_byte_q <= last_c;
		end
	end

endmodule

// ----- test/tb_note_to_midi_event_encoder_top.sv -----
`timescale 1ns / 100ps
// Testbench of note_to_midi_event_encoder_top: sends note and rest requests, predicts the
// MIDI track bytes for each and checks them in order. Depends on nmee_pkg and the encoder RTL.
module tb_note_to_midi_event_encoder_top;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 24;

	typedef struct packed {
		logic                         rest;
		logic [nmee_pkg::PITCH_W-1:0] key;
		logic [nmee_pkg::DUR_W-1:0]   beats;
		logic                         closes;
	} note_req_t;

	typedef struct packed {
		logic [nmee_pkg::BYTE_W-1:0] value;
		logic                        tail;
	} midi_byte_t;

	logic                         clk;
	logic                         arst_n     = 1'b0;
	logic                         cfg_we     = 1'b0;
	logic                         cfg_index  = nmee_pkg::REG_TIME_CLOCK;
	logic [nmee_pkg::CFG_W-1:0]   cfg_data   = '0;
	logic                         in_valid   = 1'b0;
	logic                         in_ready;
	logic                         is_rest    = 1'b0;
	logic [nmee_pkg::PITCH_W-1:0] pitch      = '0;
	logic [nmee_pkg::DUR_W-1:0]   duration   = '0;
	logic                         final_item = 1'b0;
	logic                         out_valid;
	logic                         out_ready  = 1'b0;
	logic [nmee_pkg::BYTE_W-1:0]  out_byte;
	logic                         last_byte;

	note_req_t  note_reqs[$];
	midi_byte_t midi_bytes_due[$];
	note_req_t  next_req;
	midi_byte_t want;

	logic [nmee_pkg::TC_W-1:0]   tc_copy    = nmee_pkg::TIME_CLOCK_RST;
	logic [nmee_pkg::VEL_W-1:0]  vel_copy   = nmee_pkg::VELOCITY_RST;
	logic [nmee_pkg::TICK_W-1:0] delta_owed = '0;

	logic req_taken = 1'b0;
	logic calm      = 1'b0;
	int   idle_pct  = 25;
	int   send_gap  = 0;
	int   hold_gap  = 0;
	int   mismatch_count = 0;
	int   cycle_count    = 0;

	note_to_midi_event_encoder_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.is_rest    (is_rest),
		.pitch      (pitch),
		.duration   (duration),
		.final_item (final_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.last_byte  (last_byte)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic logic [nmee_pkg::TICK_W-1:0] clamp_ticks(
		input logic [nmee_pkg::PROD_W:0] v);
		return (v > (nmee_pkg::PROD_W+1)'(nmee_pkg::TICK_MAX)) ? nmee_pkg::TICK_MAX
			: nmee_pkg::TICK_W'(v);
	endfunction

	task automatic push_byte(input logic [nmee_pkg::BYTE_W-1:0] b);
		midi_byte_t e;
		e.value = b;
		e.tail  = 1'b0;
		midi_bytes_due.insert(midi_bytes_due.size(), e);
	endtask

	task automatic push_vlq(input logic [nmee_pkg::TICK_W-1:0] v);
		int len;
		len = 1;
		while (len < nmee_pkg::VLQ_MAX_BYTES && (v >> (7 * len)) != '0)
			len++;
		for (int i = len; i > 0; i--)
			push_byte({i > 1, v[7 * (i - 1) +: 7]});
	endtask

	task automatic encode_midi_request(input note_req_t r);
		logic [nmee_pkg::PROD_W:0]   whole;
		logic [nmee_pkg::TICK_W-1:0] ticks;
		int                          start_n;
		start_n = midi_bytes_due.size();
		whole = ((nmee_pkg::PROD_W+1)'(r.beats) * (nmee_pkg::PROD_W+1)'(tc_copy))
			>> nmee_pkg::FRAC_W;
		ticks = clamp_ticks(whole);
		if (r.rest) begin
			delta_owed = clamp_ticks((nmee_pkg::PROD_W+1)'(delta_owed)
				+ (nmee_pkg::PROD_W+1)'(ticks));
		end else begin
			push_vlq(delta_owed);
			push_byte(nmee_pkg::NOTE_ON_BYTE);
			push_byte({1'b0, r.key});
			push_byte({1'b0, vel_copy});
			push_vlq(ticks);
			push_byte(nmee_pkg::NOTE_OFF_BYTE);
			push_byte({1'b0, r.key});
			push_byte(nmee_pkg::ZERO_BYTE);
			delta_owed = '0;
		end
		if (r.closes) begin
			push_byte(nmee_pkg::EOT_DELTA);
			push_byte(nmee_pkg::META_BYTE);
			push_byte(nmee_pkg::EOT_TYPE);
			push_byte(nmee_pkg::ZERO_BYTE);
			delta_owed = '0;
		end
		if (midi_bytes_due.size() > start_n)
			midi_bytes_due[midi_bytes_due.size() - 1].tail = 1'b1;
	endtask

	task automatic queue_note(input logic r, input int k, input int d, input logic f);
		note_req_t e;
		e = '{rest: r, key: nmee_pkg::PITCH_W'(k), beats: nmee_pkg::DUR_W'(d), closes: f};
		note_reqs.insert(note_reqs.size(), e);
	endtask

	task automatic queue_random(input int n);
		int d;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0:       d = 0;
				1:       d = 24'hFFFFFF;
				2, 3, 4, 5: d = $urandom_range(0, 1023);
				6, 7:    d = $urandom_range(0, 65535);
				default: d = int'($urandom & 32'hFFFFFF);
			endcase
			queue_note($urandom_range(0, 99) < 35, $urandom_range(0, 127), d,
				$urandom_range(0, 99) < 8);
		end
	endtask

	task automatic write_reg(input logic idx, input logic [nmee_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == nmee_pkg::REG_TIME_CLOCK)
			tc_copy = val[nmee_pkg::TC_W-1:0];
		else
			vel_copy = val[nmee_pkg::VEL_W-1:0];
	endtask

	// wait for the block to go idle; rests leave no byte to wait on
	task automatic settle();
		while (note_reqs.size() != 0 || in_valid || midi_bytes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// request driver
	always @(negedge clk) begin
		if (arst_n && (!in_valid || req_taken)) begin
			req_taken = 1'b0;
			if (send_gap == 0 && !calm && $urandom_range(0, 99) < idle_pct)
				send_gap = $urandom_range(1, 13);
			if (send_gap > 0 || note_reqs.size() == 0) begin
				if (send_gap > 0)
					send_gap--;
				in_valid <= 1'b0;
			end else begin
				next_req = note_reqs.pop_front();
				in_valid   <= 1'b1;
				is_rest    <= next_req.rest;
				pitch      <= next_req.key;
				duration   <= next_req.beats;
				final_item <= next_req.closes;
			end
		end
	end

	// byte receiver stalls
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_gap == 0 && !calm && $urandom_range(0, 99) < idle_pct / 3)
				hold_gap = $urandom_range(1, 13);
			if (hold_gap > 0) begin
				hold_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// predict on request accept, check each byte taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				encode_midi_request('{rest: is_rest, key: pitch, beats: duration,
					closes: final_item});
				req_taken = 1'b1;
			end
			if (out_valid && out_ready) begin
				if (midi_bytes_due.size() == 0) begin
					$display("%0t: unexpected byte: expected none, actual %h (last %b)",
						$time, out_byte, last_byte);
					mismatch_count++;
				end else begin
					want = midi_bytes_due.pop_front();
					if (out_byte !== want.value) begin
						$display("%0t: out_byte: expected %h, actual %h",
							$time, want.value, out_byte);
						mismatch_count++;
					end
					if (last_byte !== want.tail) begin
						$display("%0t: last_byte: expected %b, actual %b",
							$time, want.tail, last_byte);
						mismatch_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_note_to_midi_event_encoder_top: done, errors");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < 7; p++) begin
			settle();
			case (p)
				0: begin
					idle_pct = 25;
					// VLQ length edges at 96 ticks per beat
					queue_note(1'b0, 0, 0, 1'b0);
					queue_note(1'b0, 127, 24'hFFFFFF, 1'b0);
					queue_note(1'b0, 60, 339, 1'b0);
					queue_note(1'b0, 61, 342, 1'b0);
					queue_note(1'b0, 62, 43689, 1'b0);
					queue_note(1'b0, 63, 43691, 1'b0);
					queue_note(1'b1, 127, 256, 1'b0);
					queue_note(1'b0, 64, 256, 1'b0);
					// rests accumulate
					queue_note(1'b1, 5, 512, 1'b0);
					queue_note(1'b1, 0, 100, 1'b0);
					queue_note(1'b0, 65, 128, 1'b0);
					queue_note(1'b1, 0, 0, 1'b0);
					queue_note(1'b0, 66, 1, 1'b0);
					queue_note(1'b0, 67, 256, 1'b1);
					// final rest drops the owed delta
					queue_note(1'b1, 0, 1000, 1'b0);
					queue_note(1'b1, 9, 200, 1'b1);
					queue_note(1'b1, 0, 0, 1'b1);
					queue_note(1'b0, 68, 384, 1'b0);
					queue_note(1'b1, 0, 24'hFFFFFF, 1'b0);
					queue_note(1'b0, 69, 255, 1'b0);
					queue_random(40);
				end
				1: begin
					idle_pct = 40;
					write_reg(nmee_pkg::REG_TIME_CLOCK, 15'd32767);
					write_reg(nmee_pkg::REG_NOTE_VELOCITY, 15'd127);
					// tick and delta saturation
					queue_note(1'b0, 127, 24'hFFFFFF, 1'b0);
					queue_note(1'b1, 0, 24'hFFFFFF, 1'b0);
					queue_note(1'b1, 0, 24'hFFFFFF, 1'b0);
					queue_note(1'b0, 0, 24'hFFFFFF, 1'b1);
					queue_note(1'b1, 0, 8, 1'b0);
					queue_note(1'b0, 1, 0, 1'b0);
					queue_random(50);
				end
				2: begin
					idle_pct = 0;
					write_reg(nmee_pkg::REG_TIME_CLOCK, 15'd1);
					write_reg(nmee_pkg::REG_NOTE_VELOCITY, 15'd0);
					queue_random(50);
				end
				3: begin
					idle_pct = 15;
					write_reg(nmee_pkg::REG_TIME_CLOCK, 15'd0);
					write_reg(nmee_pkg::REG_NOTE_VELOCITY,
						nmee_pkg::CFG_W'($urandom_range(0, 127)));
					queue_random(15);
				end
				4: begin
					idle_pct = 60;
					write_reg(nmee_pkg::REG_TIME_CLOCK,
						nmee_pkg::CFG_W'($urandom_range(1, 32767)));
					write_reg(nmee_pkg::REG_NOTE_VELOCITY, nmee_pkg::CFG_W'($urandom));
					queue_random(60);
				end
				5: begin
					idle_pct = 25;
					write_reg(nmee_pkg::REG_TIME_CLOCK,
						nmee_pkg::CFG_W'($urandom_range(1, 255)));
					write_reg(nmee_pkg::REG_NOTE_VELOCITY,
						nmee_pkg::CFG_W'($urandom_range(0, 127)));
					queue_random(60);
				end
				default: begin
					calm = 1'b1;
					idle_pct = 0;
					write_reg(nmee_pkg::REG_TIME_CLOCK, nmee_pkg::TIME_CLOCK_RST);
					write_reg(nmee_pkg::REG_NOTE_VELOCITY,
						nmee_pkg::CFG_W'(nmee_pkg::VELOCITY_RST));
					queue_random(55);
				end
			endcase
		end

		settle();
		if (mismatch_count == 0)
			$display("tb_note_to_midi_event_encoder_top: done, clean");
		else
			$display("tb_note_to_midi_event_encoder_top: done, errors");
		$finish;
	end

endmodule
